[rtl/eadf_pkg.sv]
// Shared types and constants for the escaped API frame deframer.
`default_nettype none

package eadf_pkg;

  localparam logic [7:0] START_BYTE  = 8'h7E;
  localparam logic [7:0] ESC_BYTE    = 8'h7D;
  localparam logic [7:0] ESC_XOR     = 8'h20;
  localparam logic [7:0] CSUM_BASE   = 8'hFF;
  localparam int unsigned HDR_BYTES  = 3;
  localparam int unsigned OVHD_BYTES = 4;

  // Frame parser phase, one-hot
  typedef enum logic [4:0] {
    PH_HUNT    = 5'b00001,
    PH_LEN_HI  = 5'b00010,
    PH_LEN_LO  = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_CHECK   = 5'b10000
  } phase_t;

  typedef enum logic [2:0] {
    K_PAYLOAD  = 3'd0,
    K_GOOD     = 3'd1,
    K_BAD      = 3'd2,
    K_ABORT    = 3'd3,
    K_OVERFLOW = 3'd4
  } kind_t;

  typedef struct packed {
    logic [31:0] discarded_bytes;
    logic [31:0] bad_frames;
    logic [31:0] good_frames;
    logic [15:0] declared_length;
    logic [7:0]  payload_byte;
    kind_t       kind;
  } result_t;

endpackage

`default_nettype wire

[rtl/escaped_api_frame_deframer.sv]
// Escaped API frame deframer: start hunt, unescape, length, payload stream, checksum.
//
// channel | dir | tdata (low bit up)                                  | tuser
// in_     | in  | rx_byte[7:0]                                        | -
// out_    | out | payload_byte, declared_length, good_frames,         | kind[2:0]
//         |     | bad_frames, discarded_bytes                         |
//
// One byte per cycle while in_tready is high: the parser state updates at the accepting edge
// and any result is registered on that edge, in the output register or, behind a stall, in the skid.
// A one-entry skid register behind the output register keeps input flowing
// while a result is stalled; in_tready drops only when the skid is occupied.
// Reset (synchronous, rst_n low) returns to start hunt and clears counters.
`default_nettype none

module escaped_api_frame_deframer #(
  parameter int unsigned MAX_FRAME = 256
) (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           in_tvalid,
  output logic          in_tready,
  input  wire  [7:0]    in_tdata,   // rx_byte[7:0]
  output logic          out_tvalid,
  input  wire           out_tready,
  output logic [119:0]  out_tdata,  // payload_byte[7:0], declared_length[23:8],
                                    // good_frames[55:24], bad_frames[87:56],
                                    // discarded_bytes[119:88]
  output logic [2:0]    out_tuser   // kind[2:0]
);
  import eadf_pkg::*;

  localparam logic [16:0] MaxFrame = 17'(MAX_FRAME);

  phase_t      phase_r, phase_nxt;
  logic        esc_r, esc_nxt;
  logic [15:0] flen_r, flen_nxt;
  logic [15:0] nbytes_r, nbytes_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [31:0] good_r, good_nxt;
  logic [31:0] bad_r, bad_nxt;
  logic [31:0] drop_r, drop_nxt;

  logic        res_v;
  kind_t       res_kind;
  logic [7:0]  res_byte;
  logic [15:0] res_len;
  result_t     res;

  logic        out_v_r, skid_v_r;
  result_t     out_r, skid_r;

  logic        acc;
  logic        hunting;
  logic [7:0]  b;
  logic [31:0] held;
  logic        go;

  assign acc = in_tvalid & in_tready;

  always_comb begin
    hunting = 1'b0;
    held    = 32'd0;
    case (phase_r)
      PH_LEN_HI:  held = 32'd1;
      PH_LEN_LO:  held = 32'd2;
      PH_PAYLOAD: held = 32'(HDR_BYTES) + {16'd0, nbytes_r};
      PH_CHECK:   held = 32'(HDR_BYTES) + {16'd0, nbytes_r};
      default:    hunting = 1'b1;
    endcase
  end

  always_comb begin
    phase_nxt  = phase_r;
    esc_nxt    = esc_r;
    flen_nxt   = flen_r;
    nbytes_nxt = nbytes_r;
    sum_nxt    = sum_r;
    good_nxt   = good_r;
    bad_nxt    = bad_r;
    drop_nxt   = drop_r;
    res_v      = 1'b0;
    res_kind   = K_PAYLOAD;
    res_byte   = 8'd0;
    res_len    = 16'd0;
    b          = in_tdata;
    go         = 1'b0;

    if (in_tdata == START_BYTE) begin
      if (!hunting) begin
        drop_nxt = drop_r + held;
        res_v    = 1'b1;
        res_kind = K_ABORT;
        res_len  = flen_r;
      end
      phase_nxt  = PH_LEN_HI;
      esc_nxt    = 1'b0;
      flen_nxt   = 16'd0;
      nbytes_nxt = 16'd0;
      sum_nxt    = 8'd0;
    end else if (hunting) begin
      phase_nxt = PH_HUNT;
      esc_nxt   = 1'b0;
      drop_nxt  = drop_r + 32'd1;
    end else if (esc_r) begin
      b       = in_tdata ^ ESC_XOR;
      esc_nxt = 1'b0;
      go      = 1'b1;
    end else if (in_tdata == ESC_BYTE) begin
      esc_nxt = 1'b1;
    end else begin
      go = 1'b1;
    end

    if (go) begin
      case (phase_r)
        PH_LEN_HI: begin
          flen_nxt  = {b, 8'd0};
          phase_nxt = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          flen_nxt = {flen_r[15:8], b};
          if ({1'b0, flen_nxt} + 17'(OVHD_BYTES) > MaxFrame) begin
            drop_nxt  = drop_r + 32'(HDR_BYTES);
            phase_nxt = PH_HUNT;
            res_v     = 1'b1;
            res_kind  = K_OVERFLOW;
            res_len   = flen_nxt;
          end else if (flen_nxt == 16'd0) begin
            phase_nxt = PH_CHECK;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          sum_nxt    = sum_r + b;
          nbytes_nxt = nbytes_r + 16'd1;
          if (nbytes_nxt >= flen_r) phase_nxt = PH_CHECK;
          res_v    = 1'b1;
          res_kind = K_PAYLOAD;
          res_byte = b;
          res_len  = flen_r;
        end
        default: begin
          phase_nxt = PH_HUNT;
          res_v     = 1'b1;
          res_len   = flen_r;
          if (CSUM_BASE - sum_r == b) begin
            good_nxt = good_r + 32'd1;
            res_kind = K_GOOD;
          end else begin
            bad_nxt  = bad_r + 32'd1;
            res_kind = K_BAD;
          end
        end
      endcase
    end

    res.kind            = res_kind;
    res.payload_byte    = res_byte;
    res.declared_length = res_len;
    res.good_frames     = good_nxt;
    res.bad_frames      = bad_nxt;
    res.discarded_bytes = drop_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      esc_r    <= 1'b0;
      flen_r   <= 16'd0;
      nbytes_r <= 16'd0;
      sum_r    <= 8'd0;
      good_r   <= 32'd0;
      bad_r    <= 32'd0;
      drop_r   <= 32'd0;
    end else if (acc) begin
      phase_r  <= phase_nxt;
      esc_r    <= esc_nxt;
      flen_r   <= flen_nxt;
      nbytes_r <= nbytes_nxt;
      sum_r    <= sum_nxt;
      good_r   <= good_nxt;
      bad_r    <= bad_nxt;
      drop_r   <= drop_nxt;
    end
  end

  // Output register with skid entry
  logic new_res;
  logic out_free;
  assign new_res  = acc & res_v;
  assign out_free = ~out_v_r | out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_free) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= new_res;
      end else begin
        out_v_r  <= new_res;
      end
    end else if (new_res) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_v_r) begin
        out_r  <= skid_r;
        skid_r <= res;
      end else begin
        out_r  <= res;
      end
    end else if (new_res) begin
      skid_r <= res;
    end
  end

  assign in_tready  = ~skid_v_r;
  assign out_tvalid = out_v_r;
  assign out_tuser  = out_r.kind;
  assign out_tdata  = {out_r.discarded_bytes, out_r.bad_frames, out_r.good_frames,
                       out_r.declared_length, out_r.payload_byte};

endmodule

`default_nettype wire

[bench/escaped_api_frame_deframer_tb.sv]
// Self-checking bench for the escaped API frame deframer: byte stream in, event stream out.
`timescale 1ns / 100ps

module escaped_api_frame_deframer_tb;
  import eadf_pkg::*;

  localparam int unsigned MAX_FRAME    = 256;
  localparam int          RANDOM_ITEMS = 600;
  localparam longint      TIMEOUT_NS   = 64'd8_000_000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = 8'h00;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [119:0] out_tdata;
  logic [2:0]   out_tuser;

  escaped_api_frame_deframer #(
    .MAX_FRAME(MAX_FRAME)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #4 clk = ~clk;

  // Deframer prediction state
  phase_t      rx_phase = PH_HUNT;
  bit          esc_pend = 1'b0;
  logic [15:0] flen = '0;
  logic [15:0] nbytes = '0;
  logic [7:0]  csum_acc = '0;
  logic [31:0] n_good = '0;
  logic [31:0] n_bad = '0;
  logic [31:0] n_dropped = '0;

  result_t due_events[$];

  int errors = 0;
  int bytes_fed = 0;
  int noise_fed = 0;
  int events_checked = 0;
  int kind_seen[5] = '{default: 0};

  int src_gap_pct = 0;
  int sink_stall_pct = 0;
  int sink_hold = 0;
  int stall_left = 0;

  function automatic result_t make_event(kind_t k, logic [7:0] pb);
    result_t r;
    r.kind            = k;
    r.payload_byte    = pb;
    r.declared_length = flen;
    r.good_frames     = n_good;
    r.bad_frames      = n_bad;
    r.discarded_bytes = n_dropped;
    return r;
  endfunction

  function automatic void open_frame();
    rx_phase = PH_LEN_HI;
    esc_pend = 1'b0;
    flen     = '0;
    nbytes   = '0;
    csum_acc = '0;
  endfunction

  // Advance the deframer by one raw byte; returns 1 when an event comes out.
  function automatic bit deframe_step(input logic [7:0] raw, output result_t ev);
    logic [7:0] b;
    b  = raw;
    ev = '0;
    if (b == START_BYTE) begin
      if (rx_phase == PH_HUNT) begin
        open_frame();
        return 1'b0;
      end
      case (rx_phase)
        PH_LEN_HI: n_dropped += 32'd1;
        PH_LEN_LO: n_dropped += 32'd2;
        default:   n_dropped += HDR_BYTES + 32'(nbytes);
      endcase
      ev = make_event(K_ABORT, 8'h00);
      open_frame();
      return 1'b1;
    end
    if (rx_phase == PH_HUNT) begin
      esc_pend = 1'b0;
      n_dropped += 32'd1;
      return 1'b0;
    end
    if (esc_pend) begin
      b ^= ESC_XOR;
      esc_pend = 1'b0;
    end else if (b == ESC_BYTE) begin
      esc_pend = 1'b1;
      return 1'b0;
    end
    case (rx_phase)
      PH_LEN_HI: begin
        flen = {b, 8'h00};
        rx_phase = PH_LEN_LO;
        return 1'b0;
      end
      PH_LEN_LO: begin
        flen[7:0] = b;
        if (32'(flen) + OVHD_BYTES > MAX_FRAME) begin
          n_dropped += HDR_BYTES;
          rx_phase = PH_HUNT;
          ev = make_event(K_OVERFLOW, 8'h00);
          return 1'b1;
        end
        rx_phase = (flen == 16'd0) ? PH_CHECK : PH_PAYLOAD;
        return 1'b0;
      end
      PH_PAYLOAD: begin
        csum_acc += b;
        nbytes   += 16'd1;
        if (nbytes >= flen) rx_phase = PH_CHECK;
        ev = make_event(K_PAYLOAD, b);
        return 1'b1;
      end
      default: begin
        rx_phase = PH_HUNT;
        if (8'(CSUM_BASE - csum_acc) == b) begin
          n_good += 32'd1;
          ev = make_event(K_GOOD, 8'h00);
        end else begin
          n_bad += 32'd1;
          ev = make_event(K_BAD, 8'h00);
        end
        return 1'b1;
      end
    endcase
  endfunction

  task automatic send_rx_byte(input logic [7:0] b);
    result_t ev;
    if (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    bytes_fed++;
    if (deframe_step(b, ev)) due_events.push_back(ev);
  endtask

  // Escape what must be escaped, and now and then a byte that need not be.
  task automatic send_coded(input logic [7:0] b, input int esc_pct);
    if (b == START_BYTE || b == ESC_BYTE ||
        ((b ^ ESC_XOR) != START_BYTE && $urandom_range(0, 99) < esc_pct)) begin
      send_rx_byte(ESC_BYTE);
      send_rx_byte(b ^ ESC_XOR);
    end else begin
      send_rx_byte(b);
    end
  endtask

  // cut >= 0 stops the frame before that body byte, maybe leaving an escape open.
  task automatic send_frame(input logic [15:0] len, input bit corrupt, input int cut,
                            input int esc_pct);
    logic [7:0] body[$];
    logic [7:0] sum;
    logic [7:0] pb;
    int i;
    sum = '0;
    body.push_back(len[15:8]);
    body.push_back(len[7:0]);
    if (32'(len) + OVHD_BYTES <= MAX_FRAME) begin
      for (i = 0; i < int'(len); i++) begin
        case ($urandom_range(0, 11))
          0:       pb = START_BYTE;
          1:       pb = ESC_BYTE;
          2:       pb = 8'h00;
          3:       pb = 8'hFF;
          default: pb = 8'($urandom_range(0, 255));
        endcase
        sum += pb;
        body.push_back(pb);
      end
      pb = CSUM_BASE - sum;
      if (corrupt) pb ^= 8'($urandom_range(1, 255));
      body.push_back(pb);
    end
    send_rx_byte(START_BYTE);
    for (i = 0; i < body.size(); i++) begin
      if (i == cut) begin
        if ($urandom_range(0, 1) == 1) send_rx_byte(ESC_BYTE);
        return;
      end
      send_coded(body[i], esc_pct);
    end
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      errors++;
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    result_t e;
    if (rst_n && $isunknown(out_tvalid)) begin
      $display("%0t: out_tvalid unknown, expected 0 or 1, got %b", $time, out_tvalid);
      errors++;
    end else if (rst_n && out_tvalid && out_tready) begin
      if (due_events.size() == 0) begin
        $display("%0t: unexpected result, expected none, got kind %0d data %h",
                 $time, out_tuser, out_tdata);
        errors++;
      end else begin
        e = due_events.pop_front();
        check_field("kind", 32'(e.kind), 32'(out_tuser));
        check_field("payload_byte", 32'(e.payload_byte), 32'(out_tdata[7:0]));
        check_field("declared_length", 32'(e.declared_length), 32'(out_tdata[23:8]));
        check_field("good_frames", e.good_frames, out_tdata[55:24]);
        check_field("bad_frames", e.bad_frames, out_tdata[87:56]);
        check_field("discarded_bytes", e.discarded_bytes, out_tdata[119:88]);
        events_checked++;
        if (e.kind <= K_OVERFLOW) kind_seen[e.kind]++;
      end
    end
  end

  // Receiver: a long hold when requested, otherwise random stall bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (sink_hold > 0) begin
      sink_hold--;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct) begin
      stall_left = $urandom_range(1, 16) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic test_stray_bytes();
    send_rx_byte(8'h00);
    send_rx_byte(ESC_BYTE);
    send_rx_byte(8'hFF);
  endtask

  // Escaped start and escape bytes in the payload, escaped checksum
  task automatic test_escaped_frame();
    send_rx_byte(START_BYTE);
    send_rx_byte(8'h00);
    send_rx_byte(8'h02);
    send_rx_byte(ESC_BYTE);
    send_rx_byte(START_BYTE ^ ESC_XOR);
    send_rx_byte(ESC_BYTE);
    send_rx_byte(ESC_BYTE);
    send_rx_byte(ESC_BYTE);
    send_rx_byte(8'h24 ^ ESC_XOR);
  endtask

  // Zero length with an escaped length byte; checksum must be 0xFF
  task automatic test_zero_length();
    send_rx_byte(START_BYTE);
    send_rx_byte(ESC_BYTE);
    send_rx_byte(8'h00 ^ ESC_XOR);
    send_rx_byte(8'h00);
    send_rx_byte(CSUM_BASE);
  endtask

  task automatic test_bad_checksum();
    send_rx_byte(START_BYTE);
    send_rx_byte(8'h00);
    send_rx_byte(8'h01);
    send_rx_byte(8'hFF);
    send_rx_byte(8'h01);
  endtask

  // Start byte while an escape is open in the payload; frame left in length phase
  task automatic test_abort();
    send_rx_byte(START_BYTE);
    send_rx_byte(8'h00);
    send_rx_byte(8'h01);
    send_rx_byte(ESC_BYTE);
    send_rx_byte(START_BYTE);
  endtask

  // Smallest oversize length; its start byte also aborts the open frame
  task automatic test_overflow();
    send_rx_byte(START_BYTE);
    send_rx_byte(8'h00);
    send_rx_byte(8'hFD);
    test_stray_bytes();
  endtask

  task automatic test_random_frames();
    int start_items;
    int frames;
    int pick;
    logic [15:0] len;
    int esc;
    start_items = bytes_fed - noise_fed;
    frames = 0;
    while (bytes_fed - noise_fed - start_items < RANDOM_ITEMS) begin
      if (frames % 16 == 0) begin
        case ($urandom_range(0, 2))
          0:       src_gap_pct = 0;
          1:       src_gap_pct = 25;
          default: src_gap_pct = 60;
        endcase
        case ($urandom_range(0, 2))
          0:       sink_stall_pct = 0;
          1:       sink_stall_pct = 25;
          default: sink_stall_pct = 60;
        endcase
      end
      frames++;
      len = ($urandom_range(0, 29) == 0) ? 16'($urandom_range(13, 252))
                                         : 16'($urandom_range(0, 12));
      esc = ($urandom_range(0, 3) == 0) ? 20 : 0;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_frame(len, 1'b0, -1, esc);
      end else if (pick < 80) begin
        send_frame(len, 1'b1, -1, esc);
      end else if (pick < 88) begin
        send_frame(len, 1'b0, $urandom_range(0, int'(len) + 2), esc);
      end else if (pick < 94) begin
        case ($urandom_range(0, 2))
          0:       len = 16'd253;
          1:       len = 16'hFFFF;
          default: len = 16'($urandom_range(253, 65535));
        endcase
        send_frame(len, 1'b0, -1, esc);
      end else begin
        repeat ($urandom_range(1, 6)) begin
          noise_fed++;
          send_rx_byte(8'($urandom_range(0, 255)));
        end
      end
    end
  endtask

  // Receiver holds off while a longest-length frame is offered back to back
  task automatic test_backpressure();
    src_gap_pct = 0;
    sink_stall_pct = 0;
    sink_hold = 400;
    send_frame(16'(MAX_FRAME - OVHD_BYTES), 1'b0, -1, 10);
  endtask

  task automatic test_full_rate();
    src_gap_pct = 0;
    sink_stall_pct = 0;
    repeat (30) send_frame(16'($urandom_range(0, 12)), $urandom_range(0, 4) == 0, -1, 10);
  endtask

  initial begin
    #(TIMEOUT_NS);
    $display("tb: failure");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    src_gap_pct = 30;
    sink_stall_pct = 30;
    test_stray_bytes();
    test_escaped_frame();
    test_zero_length();
    test_bad_checksum();
    test_abort();
    test_overflow();
    test_random_frames();
    test_backpressure();
    test_full_rate();
    in_tvalid <= 1'b0;
    while (due_events.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    $display("summary: %0d bytes fed (%0d noise), %0d results checked",
             bytes_fed, noise_fed, events_checked);
    $display("summary: payload %0d, good %0d, bad %0d, abort %0d, overflow %0d",
             kind_seen[K_PAYLOAD], kind_seen[K_GOOD], kind_seen[K_BAD],
             kind_seen[K_ABORT], kind_seen[K_OVERFLOW]);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[files.f]
rtl/eadf_pkg.sv
rtl/escaped_api_frame_deframer.sv
bench/escaped_api_frame_deframer_tb.sv
